// ===== rtl/binary_search_with_probe_count_unit_assert.svh =====
// Assertion macros for the binary search unit
`ifndef BINARY_SEARCH_WITH_PROBE_COUNT_UNIT_ASSERT_SVH
`define BINARY_SEARCH_WITH_PROBE_COUNT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BSWP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("binary search unit: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define BSWP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("binary search unit: next-cycle check failed");

`endif

// ===== rtl/bswp_pkg.sv =====
// Shared types and constants for the binary search unit
`default_nettype none

package bswp_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_W           = 32;
    localparam int IDX_W           = 10;
    localparam int PROBE_W         = 4;
    localparam int SIZE_W          = 11;

    localparam logic               REQ_WRITE  = 1'b0;
    localparam logic               REQ_SEARCH = 1'b1;
    localparam logic [PROBE_W-1:0] PROBE_MAX  = 4'd15;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   match_index;
        logic [PROBE_W-1:0] probe_count;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/binary_search_with_probe_count_unit.sv =====
// Binary search unit: key table, search sequencer, result register
// A write item goes to the table as it is accepted; a search item runs P
// probes (0 .. log2(TABLE_DEPTH)+1) at one table read per cycle, then waits
// for the output register to take its result; only then is a new item taken.
// A finished result sits in the output register while the next item enters.
// Reset (synchronous, active low) clears the sequencer, output valid and
// table_size; table contents are undefined until written.
`default_nettype none

module binary_search_with_probe_count_unit
    import bswp_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [47:0]       s_axis_tdata,  // entry_index[9:0], key_value[41:10], zero fill
    input  wire logic              s_axis_tuser,  // req_type
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [15:0]       m_axis_tdata,  // match_index[9:0], probe_count[13:10], zero fill
    output logic                   m_axis_tuser,  // found
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [SIZE_W-1:0] i_cfg_data     // table_size
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = $clog2(TABLE_DEPTH + 1);

    logic [SIZE_W-1:0] r_table_size;
    logic [SW-1:0]     w_size;
    logic              r_m_valid;
    t_result           r_m_res;

    logic              w_mem_we, w_mem_re;
    logic [AW-1:0]     w_mem_waddr, w_mem_raddr;
    logic [KEY_W-1:0]  w_mem_wdata, w_mem_rdata;
    logic              w_res_valid, w_res_ready;
    t_result           w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_table_size <= i_cfg_data;
        end
    end

    // Clamp the configured size to the table depth
    always_comb begin
        if (32'(r_table_size) > 32'(TABLE_DEPTH)) begin
            w_size = SW'(TABLE_DEPTH);
        end else begin
            w_size = SW'(r_table_size);
        end
    end

    bswp_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    bswp_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .SW    (SW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_req_type    (s_axis_tuser),
        .i_entry_index (s_axis_tdata[IDX_W-1:0]),
        .i_key         (s_axis_tdata[IDX_W+KEY_W-1:IDX_W]),
        .i_size        (w_size),
        .o_mem_we      (w_mem_we),
        .o_mem_waddr   (w_mem_waddr),
        .o_mem_wdata   (w_mem_wdata),
        .o_mem_re      (w_mem_re),
        .o_mem_raddr   (w_mem_raddr),
        .i_mem_rdata   (w_mem_rdata),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res),
        .i_res_ready   (w_res_ready)
    );

    // Output register: load when empty or being drained
    assign w_res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_m_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_m_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_res.found;
    assign m_axis_tdata  = {2'b00, r_m_res.probe_count, r_m_res.match_index};

endmodule

`default_nettype wire

// ===== rtl/bswp_mem.sv =====
// Key table: single write port, one registered read port
`default_nettype none

module bswp_mem
    import bswp_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(TABLE_DEPTH_DEF)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [KEY_W-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [KEY_W-1:0] o_rdata
);

    logic [KEY_W-1:0] r_mem [DEPTH];
    logic [KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/bswp_ctrl.sv =====
// Search sequencer: accepts items, drives table accesses, steps the probes
`default_nettype none
`include "binary_search_with_probe_count_unit_assert.svh"

module bswp_ctrl
    import bswp_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(TABLE_DEPTH_DEF),
    parameter int SW    = $clog2(TABLE_DEPTH_DEF + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic             i_req_type,
    input  wire logic [IDX_W-1:0] i_entry_index,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [SW-1:0]    i_size,
    output logic                  o_mem_we,
    output logic      [AW-1:0]    o_mem_waddr,
    output logic      [KEY_W-1:0] o_mem_wdata,
    output logic                  o_mem_re,
    output logic      [AW-1:0]    o_mem_raddr,
    input  wire logic [KEY_W-1:0] i_mem_rdata,
    output logic                  o_res_valid,
    output t_result               o_res,
    input  wire logic             i_res_ready
);

    t_state               r_state, n_state;
    logic [SW-1:0]        r_low, r_hi;
    logic [AW-1:0]        r_mid;
    logic [KEY_W-1:0]     r_key;
    logic [PROBE_W-1:0]   r_probes;
    logic                 r_found;
    logic [IDX_W-1:0]     r_match;

    logic                 w_accept;
    logic                 w_hit;
    logic                 w_gt;
    logic                 w_more;
    logic [SW-1:0]        w_low_nx, w_hi_nx;
    logic [SW-1:0]        w_lo_sel, w_hi_sel;
    logic [SW:0]          w_sum;

    assign w_accept = (r_state == ST_IDLE) && i_valid;

    // Compare the entry read for the current midpoint and narrow the range
    always_comb begin
        w_hit    = ($signed(i_mem_rdata) == $signed(r_key));
        w_gt     = ($signed(i_mem_rdata) >  $signed(r_key));
        w_low_nx = w_gt ? r_low : (SW'(r_mid) + SW'(1));
        w_hi_nx  = w_gt ? SW'(r_mid) : r_hi;
        w_more   = (w_low_nx < w_hi_nx);
        w_lo_sel = (r_state == ST_IDLE) ? '0 : w_low_nx;
        w_hi_sel = (r_state == ST_IDLE) ? i_size : w_hi_nx;
        // floor((low + high) / 2) with high = hi - 1
        w_sum    = {1'b0, w_lo_sel} + {1'b0, w_hi_sel} - (SW+1)'(1);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_req_type == REQ_SEARCH)) begin
                    n_state = (i_size == '0) ? ST_RESULT : ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (w_hit || !w_more) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready     = (r_state == ST_IDLE);
        o_mem_we    = w_accept && (i_req_type == REQ_WRITE)
                      && (32'(i_entry_index) < 32'(DEPTH));
        o_mem_waddr = AW'(i_entry_index);
        o_mem_wdata = i_key;
        o_mem_re    = (w_accept && (i_req_type == REQ_SEARCH))
                      || ((r_state == ST_PROBE) && !w_hit && w_more);
        o_mem_raddr = AW'(w_sum >> 1);
        o_res_valid = (r_state == ST_RESULT);
        o_res       = '{found: r_found, match_index: r_match, probe_count: r_probes};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_req_type == REQ_SEARCH)) begin
            r_low    <= '0;
            r_hi     <= i_size;
            r_mid    <= o_mem_raddr;
            r_key    <= i_key;
            r_probes <= '0;
            r_found  <= 1'b0;
            r_match  <= '0;
        end else if (r_state == ST_PROBE) begin
            // saturate the probe count
            if (r_probes != PROBE_MAX) begin
                r_probes <= r_probes + PROBE_W'(1);
            end
            if (w_hit) begin
                r_found <= 1'b1;
                r_match <= IDX_W'(r_mid);
            end else begin
                r_low <= w_low_nx;
                r_hi  <= w_hi_nx;
                r_mid <= o_mem_raddr;
            end
        end
    end

    `BSWP_ASSERT_NOW(a_probe_range, i_clk, i_rst_n,
        r_state == ST_PROBE, (r_low < r_hi) && (SW'(r_mid) < r_hi) && (SW'(r_mid) >= r_low))
    `BSWP_ASSERT_NOW(a_found_probed, i_clk, i_rst_n,
        (r_state == ST_RESULT) && r_found, r_probes != '0)
    `BSWP_ASSERT_NOW(a_write_idle, i_clk, i_rst_n,
        o_mem_we, (r_state == ST_IDLE) && !o_mem_re)
    `BSWP_ASSERT_NEXT(a_result_done, i_clk, i_rst_n,
        (r_state == ST_RESULT) && i_res_ready, r_state == ST_IDLE)

endmodule

`default_nettype wire
